// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int TOTAL_BLOCKS = 16384;
    localparam int ID_W         = 14;
    localparam int ID_SPACE     = 1 << ID_W;
    // Only ids that fit the 14-bit field can ever be tracked.
    localparam int LIMIT        = (TOTAL_BLOCKS < ID_SPACE) ? TOTAL_BLOCKS : ID_SPACE;

    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int NUM_WORDS = (LIMIT + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // The per-word full flags are scanned sixteen at a time.
    localparam int CHUNK_W    = 16;
    localparam int CPOS_W     = 4;
    localparam int NUM_CHUNKS = (NUM_WORDS + CHUNK_W - 1) / CHUNK_W;
    localparam int CADDR_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SIDX_W     = CADDR_W + CPOS_W;

    localparam int STATUS_W       = 2;
    localparam int DATA_START_RST = 1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [WADDR_W-1:0] t_waddr;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CADDR_W-1:0] t_chunk;

    typedef struct packed {
        logic   en;
        t_waddr addr;
    } t_ram_rd;

    typedef struct packed {
        logic   en;
        t_waddr addr;
        t_word  data;
    } t_ram_wr;

    typedef struct packed {
        logic   en;
        t_waddr addr;
        logic   full;
    } t_sum_upd;

    function automatic t_waddr word_of(input t_id id);
        return WADDR_W'(id >> BIT_W);
    endfunction

    // Bits of a word whose block number lies at or beyond the tracked limit.
    function automatic t_word limit_mask(input t_waddr w);
        t_word m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = ((32'(w) << BIT_W) + 32'(i)) >= 32'(LIMIT);
        end
        return m;
    endfunction

    function automatic logic [BIT_W-1:0] first_one64(input t_word v);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [CPOS_W-1:0] first_one16(input logic [CHUNK_W-1:0] v);
        logic [CPOS_W-1:0] p;
        p = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = CPOS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/bba_if.sv
`timescale 1ns / 1ps

interface bba_cmd_if import bba_pkg::*; ();
    logic valid;
    logic ready;
    logic cmd;
    t_id  block_id;

    modport source (output valid, output cmd, output block_id, input ready);
    modport sink   (input valid, input cmd, input block_id, output ready);
endinterface

interface bba_res_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    t_id                 alloc_id;

    modport source (output valid, output status, output alloc_id, input ready);
    modport sink   (input valid, input status, input alloc_id, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
    logic valid;
    logic ready;
    t_id  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bba_map_ram.sv
`timescale 1ns / 1ps

module bba_map_ram import bba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ram_rd i_rd,
    input  t_ram_wr i_wr,
    output t_word   o_rd_data
);

    t_word r_mem [NUM_WORDS];
    logic  [NUM_WORDS-1:0] r_valid;
    t_word r_rd_data;
    logic  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // A word never written since reset reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: rtl/bba_summary.sv
`timescale 1ns / 1ps

module bba_summary import bba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sum_upd           i_upd,
    input  t_chunk             i_chunk,
    output logic [CHUNK_W-1:0] o_free
);

    logic [NUM_WORDS-1:0]          r_full;
    logic [NUM_CHUNKS*CHUNK_W-1:0] full_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd.en) begin
            r_full[i_upd.addr] <= i_upd.full;
        end
    end

    // Slots past the last word count as full so the scan never picks them.
    for (genvar j = 0; j < NUM_CHUNKS * CHUNK_W; j++) begin : g_pad
        if (j < NUM_WORDS) begin : g_real
            assign full_pad[j] = r_full[j];
        end else begin : g_fill
            assign full_pad[j] = 1'b1;
        end
    end

    assign o_free = ~full_pad[{i_chunk, CPOS_W'(0)} +: CHUNK_W];

endmodule

// File: rtl/block_bitmap_allocator_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Word                     Accepted when
// i_cmd    in   cmd, block_id            i_cmd.valid && i_cmd.ready
// o_res    out  status, alloc_id         o_res.valid && o_res.ready
// i_cfg    in   data (data_start)        i_cfg.valid (ready is always high)
//
// One command at a time. A free passes S_FREE then S_PUSH, or goes straight
// to S_PUSH when the id is rejected. An allocate checks the word holding
// data_start in S_CHK; when it has no free bit, S_SCAN looks at sixteen full
// flags per step and each word found is read back into S_CHK; that is the loop.
// Reset clears the per-word valid and full flags at once; no sweep.
// A result waiting on o_res holds the next command back only once it is done.

module block_bitmap_allocator_unit import bba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bba_cmd_if.sink   i_cmd,
    bba_res_if.source o_res,
    bba_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_FREE,
        S_PUSH
    } t_state;

    t_state  r_state;
    t_id     r_data_start;
    t_id     r_id;
    t_waddr  r_word_addr;
    t_chunk  r_chunk;
    logic [CPOS_W-1:0] r_low;
    t_status r_status;
    t_id     r_alloc_id;
    logic    r_out_valid;
    t_status r_o_status;
    t_id     r_o_alloc_id;

    t_ram_rd  ram_rd;
    t_ram_wr  ram_wr;
    t_sum_upd sum_upd;
    t_word    rd_word;
    logic [CHUNK_W-1:0] chunk_free;

    logic              in_acc;
    t_waddr            w0;
    t_waddr            in_addr;
    t_word             below;
    t_word             avail;
    logic              hit;
    logic [BIT_W-1:0]  pos;
    t_word             n_alloc_word;
    t_word             n_free_word;
    logic [SIDX_W:0]   next_idx;
    logic [CHUNK_W-1:0] cand;
    logic              found;
    logic [CPOS_W-1:0] spos;

    bba_map_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (ram_rd),
        .i_wr      (ram_wr),
        .o_rd_data (rd_word)
    );

    bba_summary u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (sum_upd),
        .i_chunk (r_chunk),
        .o_free  (chunk_free)
    );

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign in_acc         = i_cmd.valid && i_cmd.ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.status   = r_o_status;
    assign o_res.alloc_id = r_o_alloc_id;

    assign w0      = word_of(r_data_start);
    assign in_addr = (i_cmd.cmd == CMD_FREE) ? word_of(i_cmd.block_id) : w0;

    always_comb begin
        // Blocks below data_start are metadata; they only share the word holding data_start.
        for (int i = 0; i < WORD_W; i++) begin
            below[i] = (r_word_addr == w0) && (BIT_W'(i) < r_data_start[BIT_W-1:0]);
        end
        avail        = ~(rd_word | below | limit_mask(r_word_addr));
        hit          = |avail;
        pos          = first_one64(avail);
        n_alloc_word = rd_word | (t_word'(1) << pos);
        n_free_word  = rd_word & ~(t_word'(1) << r_id[BIT_W-1:0]);
        next_idx     = {1'b0, SIDX_W'(r_word_addr)} + (SIDX_W + 1)'(1);
        for (int i = 0; i < CHUNK_W; i++) begin
            cand[i] = chunk_free[i] && (CPOS_W'(i) >= r_low);
        end
        found = |cand;
        spos  = first_one16(cand);
    end

    always_comb begin
        ram_rd  = '0;
        ram_wr  = '0;
        sum_upd = '0;
        unique case (r_state)
            S_IDLE: begin
                ram_rd.en   = in_acc;
                ram_rd.addr = in_addr;
            end
            S_CHK: begin
                ram_wr.en    = hit;
                ram_wr.addr  = r_word_addr;
                ram_wr.data  = n_alloc_word;
                sum_upd.en   = hit;
                sum_upd.addr = r_word_addr;
                sum_upd.full = &(n_alloc_word | limit_mask(r_word_addr));
            end
            S_SCAN: begin
                ram_rd.en   = found;
                ram_rd.addr = WADDR_W'({r_chunk, spos});
            end
            S_FREE: begin
                ram_wr.en    = 1'b1;
                ram_wr.addr  = r_word_addr;
                ram_wr.data  = n_free_word;
                sum_upd.en   = 1'b1;
                sum_upd.addr = r_word_addr;
                sum_upd.full = 1'b0;
            end
            S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_data_start <= ID_W'(DATA_START_RST);
        end else begin
            if (i_cfg.valid) begin
                r_data_start <= i_cfg.data;
            end
            if ((r_state == S_PUSH) && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_id        <= i_cmd.block_id;
                        r_word_addr <= in_addr;
                        r_alloc_id  <= '0;
                        if (i_cmd.cmd == CMD_FREE) begin
                            if ((32'(i_cmd.block_id) >= 32'(LIMIT)) ||
                                (i_cmd.block_id < r_data_start)) begin
                                r_status <= ST_RANGE;
                                r_state  <= S_PUSH;
                            end else begin
                                r_state <= S_FREE;
                            end
                        end else if (32'(r_data_start) >= 32'(LIMIT)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_PUSH;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (hit) begin
                        r_status   <= ST_OK;
                        r_alloc_id <= ID_W'({r_word_addr, pos});
                        r_state    <= S_PUSH;
                    end else if (32'(next_idx) >= 32'(NUM_WORDS)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_PUSH;
                    end else begin
                        r_chunk <= next_idx[SIDX_W-1:CPOS_W];
                        r_low   <= next_idx[CPOS_W-1:0];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        r_word_addr <= WADDR_W'({r_chunk, spos});
                        r_state     <= S_CHK;
                    end else if (r_chunk == CADDR_W'(NUM_CHUNKS - 1)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_PUSH;
                    end else begin
                        r_chunk <= r_chunk + CADDR_W'(1);
                        r_low   <= '0;
                    end
                end
                S_FREE: begin
                    r_status <= ST_OK;
                    r_state  <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_o_status   <= r_status;
                        r_o_alloc_id <= r_alloc_id;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 30;
    localparam int FLOOD_HOLD = 400;

    typedef enum bit {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_status status;
        t_id     alloc_id;
    } t_alloc_result;

    typedef struct {
        t_row_kind     kind;
        logic          op;
        t_id           id;
        bit            typed;
        t_alloc_result res;
    } t_stim_row;

    typedef struct {
        t_id start;
        int  count;
        int  alloc_pct;
        bit  quiet;
        bit  flood;
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    bba_cmd_if cmd_bus ();
    bba_res_if res_bus ();
    bba_cfg_if cfg_bus ();

    block_bitmap_allocator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Shadow copy of the bitmap and of the data start register.
    bit            used_map [LIMIT];
    t_id           cur_start;
    t_id           held_ids [$];
    t_alloc_result owed_results [$];

    int  mismatches;
    int  cycle_count;
    int  hold_request;
    bit  quiet_mode;

    t_stim_row plan [] = '{
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b1, '{ST_OK,    14'd1024}},
        '{ROW_CMD, CMD_ALLOC, 14'd16383, 1'b1, '{ST_OK,    14'd1025}},
        '{ROW_CMD, CMD_FREE,  14'd16383, 1'b1, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd0,     1'b1, '{ST_RANGE, 14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd1023,  1'b1, '{ST_RANGE, 14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd1024,  1'b1, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd5,     1'b1, '{ST_OK,    14'd1024}},
        '{ROW_CMD, CMD_FREE,  14'd1025,  1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd1025,  1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd10922, 1'b0, '{ST_OK,    14'd0}},
        '{ROW_CFG, CMD_ALLOC, 14'd16383, 1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd5461,  1'b1, '{ST_OK,    14'd16383}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b1, '{ST_FULL,  14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd16382, 1'b1, '{ST_RANGE, 14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd16383, 1'b1, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b1, '{ST_OK,    14'd16383}},
        '{ROW_CFG, CMD_ALLOC, 14'd0,     1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b1, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd0,     1'b1, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b0, '{ST_OK,    14'd0}},
        '{ROW_CFG, CMD_ALLOC, 14'd1,     1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_FREE,  14'd0,     1'b1, '{ST_RANGE, 14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b0, '{ST_OK,    14'd0}},
        '{ROW_CFG, CMD_ALLOC, 14'd16320, 1'b0, '{ST_OK,    14'd0}},
        '{ROW_CMD, CMD_ALLOC, 14'd0,     1'b0, '{ST_OK,    14'd0}}
    };

    t_phase phases [] = '{
        '{14'd1024,  200, 55, 1'b0, 1'b0},
        '{14'd16200, 300, 70, 1'b0, 1'b1},
        '{14'd1000,  200, 65, 1'b0, 1'b0},
        '{14'd1,     150, 50, 1'b1, 1'b0},
        '{14'd16383,  80, 50, 1'b0, 1'b0},
        '{14'd0,     100, 60, 1'b0, 1'b0},
        '{14'd8191,  200, 60, 1'b0, 1'b1},
        '{14'd16376, 120, 55, 1'b1, 1'b0},
        '{14'd2047,  180, 75, 1'b0, 1'b0}
    };

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // First fit from the data start up to the tracked limit; a free in range clears one bit.
    function automatic t_alloc_result predict_bitmap_op(input logic op, input t_id id);
        t_alloc_result r;
        int            hit [$];
        r.status   = ST_OK;
        r.alloc_id = '0;
        if (op == CMD_ALLOC) begin
            r.status = ST_FULL;
            for (int b = int'(cur_start); b < LIMIT; b++) begin
                if (!used_map[b]) begin
                    used_map[b] = 1'b1;
                    r.status    = ST_OK;
                    r.alloc_id  = t_id'(b);
                    held_ids.push_back(t_id'(b));
                    break;
                end
            end
        end else if (int'(id) >= LIMIT || id < cur_start) begin
            r.status = ST_RANGE;
        end else begin
            used_map[id] = 1'b0;
            hit = held_ids.find_first_index(x) with (x == id);
            if (hit.size() != 0) begin
                held_ids.delete(hit[0]);
            end
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Frees mostly hit blocks in use, some land around the data start, the rest anywhere.
    function automatic t_id pick_free_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && held_ids.size() > 0) begin
            return held_ids[$urandom_range(0, held_ids.size() - 1)];
        end
        if (r < 75) begin
            return t_id'(int'(cur_start) + int'($urandom_range(0, 7)) - 2);
        end
        return t_id'($urandom_range(0, ID_SPACE - 1));
    endfunction

    task automatic idle_cmd(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input logic op, input t_id id, input bit typed,
                           input t_alloc_result typed_res);
        t_alloc_result got;
        @(negedge i_clk);
        cmd_bus.valid    <= 1'b1;
        cmd_bus.cmd      <= op;
        cmd_bus.block_id <= id;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        got = predict_bitmap_op(op, id);
        owed_results.push_back(typed ? typed_res : got);
    endtask

    // The register is only touched once every result has come back.
    task automatic write_data_start(input t_id v);
        idle_cmd(1);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= v;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cur_start = v;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                res_bus.ready <= 1'b1;
                if (!quiet_mode) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: status %0d alloc_id %0d",
                             res_bus.status, res_bus.alloc_id);
                end
            end else begin
                want = owed_results.pop_front();
                if (res_bus.status !== want.status || res_bus.alloc_id !== want.alloc_id) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word mismatch: status exp %0d got %0d, alloc_id exp %0d got %0d",
                                 want.status, res_bus.status, want.alloc_id, res_bus.alloc_id);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int   gap;
        logic op;
        t_id  id;
        mismatches       = 0;
        cycle_count      = 0;
        hold_request     = 0;
        quiet_mode       = 1'b0;
        cur_start        = t_id'(DATA_START_RST);
        i_rst_n          = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.cmd      = CMD_ALLOC;
        cmd_bus.block_id = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;
        foreach (used_map[b]) begin
            used_map[b] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                write_data_start(plan[k].id);
            end else begin
                idle_cmd(pick_gap());
                send_op(plan[k].op, plan[k].id, plan[k].typed, plan[k].res);
            end
        end

        foreach (phases[p]) begin
            write_data_start(phases[p].start);
            quiet_mode = phases[p].quiet;
            // The sender keeps offering words while the receiver sits on its ready.
            if (phases[p].flood) begin
                hold_request = FLOOD_HOLD;
            end
            for (int n = 0; n < phases[p].count; n++) begin
                gap = quiet_mode ? 0 : pick_gap();
                idle_cmd(gap);
                if ($urandom_range(0, 99) < phases[p].alloc_pct) begin
                    op = CMD_ALLOC;
                    id = t_id'($urandom_range(0, ID_SPACE - 1));
                end else begin
                    op = CMD_FREE;
                    id = pick_free_id();
                end
                send_op(op, id, 1'b0, '0);
            end
        end

        idle_cmd(1);
        quiet_mode = 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
